// ===== src/eld_pkg.sv =====
// Shared types, widths and register indexes for the exponential level detector.
`timescale 1ns / 1ps

package eld_pkg;

	localparam int SAMPLE_W  = 48;
	localparam int VALUE_W   = 64;
	localparam int PEAK_W    = 63;
	localparam int COEF_W    = 32;
	localparam int LEN_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;
	localparam int SHIFT     = 16;

	localparam int COUNT_BITS_DEF = 16;

	localparam logic [COEF_W-1:0] GAIN_RST     = 32'd1;
	localparam logic [LEN_W-1:0]  INTERVAL_RST = 16'd1024;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [VALUE_W-1:0]  value_t;
	typedef logic [PEAK_W-1:0]          peak_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
	typedef logic [CFG_DAT_W-1:0]       cfg_dat_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FEEDBACK = 2'd0,
		REG_GAIN     = 2'd1,
		REG_INTERVAL = 2'd2
	} cfg_reg_t;

endpackage

// ===== src/eld_if.sv =====
// Stream and configuration channel interfaces for the level detector.
`timescale 1ns / 1ps

interface eld_sample_if;
	import eld_pkg::*;
	logic    valid;
	logic    ready;
	sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface eld_result_if;
	import eld_pkg::*;
	logic   valid;
	logic   ready;
	value_t smoothed;
	logic   interval_done;
	value_t interval_first;
	peak_t  interval_max;

	modport source (output valid, output smoothed, output interval_done,
		output interval_first, output interval_max, input ready);
	modport sink (input valid, input smoothed, input interval_done,
		input interval_first, input interval_max, output ready);
endinterface

interface eld_cfg_if;
	import eld_pkg::*;
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	cfg_dat_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/exponential_level_detector_top.sv =====
// Exponential level detector: one-pole smoother with interval first/max report.
//
//  channel     dir  word                                         accepted when
//  sample_ch   in   sample (48b signed)                          valid && ready
//  result_ch   out  smoothed, interval_done/_first/_max          valid && ready
//  cfg         in   index (2b), data (32b); 0 fb, 1 gain, 2 len   valid && ready
//
// Three register stages: input word, gain product (split 32-bit partial
// products), then the feedback recursion into the result register.
// One word per cycle sustained while result_ch is ready.
// The feedback product, the add of the gain term and the peak compare set the
// cycle time.
// Result stalls back up through the stages; a bubble is filled at once.
// Reset clears the filter memory, interval position, first value and peak.
`timescale 1ns / 1ps

module exponential_level_detector_top #(
	parameter int COUNT_BITS = eld_pkg::COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	eld_sample_if.sink         sample_ch,
	eld_result_if.source       result_ch,
	eld_cfg_if.sink            cfg
);
	import eld_pkg::*;

	// config
	logic signed [COEF_W:0]   fb_neg_q;
	logic signed [COEF_W-1:0] gain_q;
	logic [LEN_W-1:0]         len_q;

	// pipeline
	logic    v_s1, v_s2, v_s3;
	sample_t sample_s1;
	value_t  gx_s2;
	logic    rdy_s1, rdy_s2, rdy_s3;
	logic    adv_s1, adv_s2;

	// state
	value_t                mem_q;
	value_t                first_q;
	peak_t                 peak_q;
	logic [COUNT_BITS-1:0] pos_q;

	// result registers
	value_t smoothed_s3;
	logic   done_s3;
	value_t first_s3;
	peak_t  max_s3;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_neg_q <= '0;
			gain_q   <= GAIN_RST;
			len_q    <= INTERVAL_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FEEDBACK: fb_neg_q <= -$signed({cfg.data[COEF_W-1], cfg.data});
				REG_GAIN:     gain_q   <= $signed(cfg.data);
				REG_INTERVAL: len_q    <= cfg.data[LEN_W-1:0];
				default:      ;
			endcase
		end
	end

	assign rdy_s3 = !v_s3 || result_ch.ready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign adv_s2 = v_s2 && rdy_s3;
	assign adv_s1 = v_s1 && rdy_s2;
	assign sample_ch.ready = rdy_s1;

	// gain * sample mod 2^64, split on the sample's low word
	logic signed [2*COEF_W+1:0]         gp_lo;
	logic signed [COEF_W+SAMPLE_W-33:0] gp_hi;
	value_t                             gx_c;

	assign gp_lo = (2*COEF_W+2)'(gain_q) *
		(2*COEF_W+2)'($signed({1'b0, sample_s1[31:0]}));
	assign gp_hi = (COEF_W+SAMPLE_W-32)'(gain_q) *
		(COEF_W+SAMPLE_W-32)'($signed(sample_s1[SAMPLE_W-1:32]));
	assign gx_c  = gp_lo[VALUE_W-1:0] + {gp_hi[31:0], 32'b0};

	// feedback: (-a1 * mem) mod 2^64, split on the memory's halves
	logic signed [2*COEF_W+1:0] fp_lo;
	logic [31:0]                fp_hi;
	value_t                     fprod;
	value_t                     y_c;

	assign fp_lo = (2*COEF_W+2)'(fb_neg_q) *
		(2*COEF_W+2)'($signed({1'b0, mem_q[31:0]}));
	assign fp_hi = fb_neg_q[31:0] * mem_q[63:32];
	assign fprod = fp_lo[VALUE_W-1:0] + {fp_hi, 32'b0};
	assign y_c   = (fprod >>> SHIFT) + gx_s2;

	// interval bookkeeping
	logic [COUNT_BITS-1:0] len_c, len_eff;
	logic [COUNT_BITS:0]   pos_inc;
	logic                  start_c, done_c;
	peak_t                 peak_base, peak_c;
	value_t                first_c;

	assign len_c     = COUNT_BITS'(len_q);
	assign len_eff   = (len_c == '0) ? COUNT_BITS'(1) : len_c;
	assign pos_inc   = {1'b0, pos_q} + (COUNT_BITS+1)'(1);
	assign done_c    = pos_inc >= {1'b0, len_eff};
	assign start_c   = (pos_q == '0);
	assign first_c   = start_c ? y_c : first_q;
	assign peak_base = start_c ? '0 : peak_q;
	assign peak_c    = (!y_c[VALUE_W-1] && (y_c[PEAK_W-1:0] > peak_base)) ?
		y_c[PEAK_W-1:0] : peak_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			mem_q   <= '0;
			first_q <= '0;
			peak_q  <= '0;
			pos_q   <= '0;
		end else begin
			if (rdy_s1) v_s1 <= sample_ch.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (adv_s2) begin
				mem_q   <= y_c;
				first_q <= first_c;
				peak_q  <= peak_c;
				pos_q   <= done_c ? '0 : pos_inc[COUNT_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && sample_ch.valid) sample_s1 <= sample_ch.sample;
		if (adv_s1) gx_s2 <= gx_c;
		if (adv_s2) begin
			smoothed_s3 <= y_c;
			done_s3     <= done_c;
			first_s3    <= done_c ? first_c : '0;
			max_s3      <= done_c ? peak_c : '0;
		end
	end

	assign result_ch.valid          = v_s3;
	assign result_ch.smoothed       = smoothed_s3;
	assign result_ch.interval_done  = done_s3;
	assign result_ch.interval_first = first_s3;
	assign result_ch.interval_max   = max_s3;

	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && !result_ch.interval_done |->
			result_ch.interval_first == '0 && result_ch.interval_max == '0)
		else $error("report fields set without interval_done");

	a_pos_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && done_c |=> pos_q == '0)
		else $error("interval position not cleared at interval end");

	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.ready |-> sample_ch.ready)
		else $error("input stalled while output drains");

	a_peak_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.interval_done && !result_ch.smoothed[VALUE_W-1] |->
			result_ch.interval_max >= result_ch.smoothed[PEAK_W-1:0])
		else $error("interval max below closing value");

endmodule

// ===== tb/sv/tb_exponential_level_detector_top.sv =====
// Testbench for the exponential level detector: directed table, random phases, self-checking.
`timescale 1ns / 1ps

module tb_exponential_level_detector_top;
	import eld_pkg::*;

	localparam int      CLK_HALF_NS  = 5;
	localparam int      RST_CYCLES   = 10;
	localparam int      PIPE_LAT     = 3;
	localparam longint  LIMIT_NS     = 5_000_000;
	localparam int      RAND_PHASES  = 6;
	localparam int      PHASE_ITEMS  = 150;

	localparam sample_t SMP_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam sample_t SMP_MIN = 48'sh8000_0000_0000;

	typedef struct {
		value_t smoothed;
		logic   done;
		value_t first;
		peak_t  peak;
	} level_t;

	typedef struct {
		bit       is_cfg;
		cfg_reg_t reg_sel;
		cfg_dat_t data;
		sample_t  sample;
		bit       typed;
		level_t   level;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;

	eld_sample_if sample_ch ();
	eld_result_if result_ch ();
	eld_cfg_if    cfg_ch ();

	exponential_level_detector_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg       (cfg_ch)
	);

	always #(CLK_HALF_NS) clk = ~clk;

	// predictor state
	logic signed [COEF_W-1:0] fb_coef     = '0;
	logic signed [COEF_W-1:0] gain_coef   = 32'sd1;
	logic [LEN_W-1:0]         iv_len      = INTERVAL_RST;
	value_t                   smoother_mem = '0;
	logic [LEN_W-1:0]         iv_pos      = '0;
	value_t                   iv_first    = '0;
	peak_t                    iv_peak     = '0;

	level_t pending_levels[$];
	step_t  directed_steps[$];
	level_t no_level;
	level_t got_level;
	level_t want_level;
	int     errors     = 0;
	int     stall_left = 0;
	bit     quiet      = 1'b0;
	int     idx;
	int     phase;

	function automatic level_t predict_level(sample_t x);
		value_t         xs;
		value_t         a1;
		value_t         b0;
		value_t         prod;
		value_t         y;
		logic [LEN_W-1:0] len;
		logic [LEN_W:0]   next_pos;
		level_t         lvl;
		xs   = value_t'(x);
		a1   = value_t'(fb_coef);
		b0   = value_t'(gain_coef);
		prod = -a1 * smoother_mem;
		y    = (prod >>> SHIFT) + b0 * xs;
		smoother_mem = y;
		len = (iv_len == '0) ? 16'd1 : iv_len;
		if (iv_pos == '0) begin
			iv_first = y;
			iv_peak  = '0;
		end
		if (!y[VALUE_W-1] && y[PEAK_W-1:0] > iv_peak)
			iv_peak = y[PEAK_W-1:0];
		next_pos = {1'b0, iv_pos} + (LEN_W+1)'(1);
		lvl.smoothed = y;
		lvl.done     = (next_pos >= {1'b0, len});
		lvl.first    = lvl.done ? iv_first : '0;
		lvl.peak     = lvl.done ? iv_peak : '0;
		iv_pos = lvl.done ? '0 : next_pos[LEN_W-1:0];
		return lvl;
	endfunction

	function automatic void apply_reg(cfg_reg_t sel, cfg_dat_t d);
		case (sel)
			REG_FEEDBACK: fb_coef = d;
			REG_GAIN:     gain_coef = d;
			REG_INTERVAL: iv_len = d[LEN_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic cfg_dat_t pick_coef(bit is_gain);
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return is_gain ? 32'd1 : 32'd0;
			3: return is_gain ? $urandom_range(1, 64) : -$urandom_range(32768, 65535);
			default: return $urandom();
		endcase
	endfunction

	function automatic cfg_dat_t pick_len();
		cfg_dat_t d;
		d = $urandom();
		case ($urandom_range(0, 7))
			0: d[LEN_W-1:0] = '0;
			1: d[LEN_W-1:0] = 16'd1;
			2: d[LEN_W-1:0] = 16'hFFFF;
			3: d[LEN_W-1:0] = INTERVAL_RST;
			default: d[LEN_W-1:0] = LEN_W'($urandom_range(2, 40));
		endcase
		return d;
	endfunction

	function automatic sample_t pick_sample();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		case ($urandom_range(0, 9))
			0, 1: return r[SAMPLE_W-1:0];
			2: begin
				case ($urandom_range(0, 3))
					0: return SMP_MAX;
					1: return SMP_MIN;
					2: return '0;
					default: return '1;
				endcase
			end
			3: return sample_t'(r[15:0]);
			default: return sample_t'($urandom_range(0, 1 << 20));
		endcase
	endfunction

	function automatic step_t cfg_row(cfg_reg_t sel, cfg_dat_t d);
		step_t s;
		s.is_cfg  = 1'b1;
		s.reg_sel = sel;
		s.data    = d;
		s.sample  = '0;
		s.typed   = 1'b0;
		return s;
	endfunction

	function automatic step_t smp_row(sample_t x);
		step_t s;
		s.is_cfg  = 1'b0;
		s.reg_sel = REG_FEEDBACK;
		s.data    = '0;
		s.sample  = x;
		s.typed   = 1'b0;
		return s;
	endfunction

	function automatic step_t chk_row(sample_t x, value_t sm, logic dn, value_t fi, peak_t pk);
		step_t s;
		s = smp_row(x);
		s.typed          = 1'b1;
		s.level.smoothed = sm;
		s.level.done     = dn;
		s.level.first    = fi;
		s.level.peak     = pk;
		return s;
	endfunction

	task automatic wait_drain();
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 1) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t sel, cfg_dat_t d);
		sample_ch.valid <= 1'b0;
		wait_drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= sel;
		cfg_ch.data  <= d;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		apply_reg(sel, d);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_sample(sample_t x, bit typed, level_t typed_lvl);
		int gap;
		level_t lvl;
		gap = idle_gap();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= x;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		lvl = predict_level(x);
		pending_levels.push_back(typed ? typed_lvl : lvl);
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready) begin
			got_level.smoothed = result_ch.smoothed;
			got_level.done     = result_ch.interval_done;
			got_level.first    = result_ch.interval_first;
			got_level.peak     = result_ch.interval_max;
			if (pending_levels.size() == 0) begin
				$error("result word with nothing expected: smoothed %0d", got_level.smoothed);
				errors++;
			end else begin
				want_level = pending_levels.pop_front();
				if (got_level.smoothed !== want_level.smoothed) begin
					$error("smoothed: expected %0d, actual %0d",
						want_level.smoothed, got_level.smoothed);
					errors++;
				end
				if (got_level.done !== want_level.done) begin
					$error("interval_done: expected %0d, actual %0d",
						want_level.done, got_level.done);
					errors++;
				end
				if (got_level.first !== want_level.first) begin
					$error("interval_first: expected %0d, actual %0d",
						want_level.first, got_level.first);
					errors++;
				end
				if (got_level.peak !== want_level.peak) begin
					$error("interval_max: expected %0d, actual %0d",
						want_level.peak, got_level.peak);
					errors++;
				end
			end
		end
		if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left      <= stall_left - 1;
		end else if (idle_gap() > 0) begin
			result_ch.ready <= 1'b0;
			stall_left      <= idle_gap();
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	initial begin
		arst_n           = 1'b0;
		sample_ch.valid  = 1'b0;
		sample_ch.sample = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = REG_FEEDBACK;
		cfg_ch.data      = '0;

		// reset settings: y equals the sample
		directed_steps.push_back(chk_row(SMP_MAX, 64'sh0000_7FFF_FFFF_FFFF, 1'b0, '0, '0));
		directed_steps.push_back(chk_row(SMP_MIN, 64'shFFFF_8000_0000_0000, 1'b0, '0, '0));
		directed_steps.push_back(chk_row('0, '0, 1'b0, '0, '0));
		// zero length acts as one and closes the open interval at once
		directed_steps.push_back(cfg_row(REG_INTERVAL, 32'hFFFF_0000));
		directed_steps.push_back(chk_row(48'sd5, 64'sd5, 1'b1,
			64'sh0000_7FFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF));
		directed_steps.push_back(chk_row(-48'sd7, -64'sd7, 1'b1, -64'sd7, '0));
		// most negative coefficient and gain
		directed_steps.push_back(cfg_row(REG_FEEDBACK, 32'h8000_0000));
		directed_steps.push_back(cfg_row(REG_GAIN, 32'h8000_0000));
		directed_steps.push_back(cfg_row(REG_INTERVAL, 32'd3));
		directed_steps.push_back(smp_row(SMP_MAX));
		directed_steps.push_back(smp_row(SMP_MIN));
		directed_steps.push_back(smp_row('1));
		directed_steps.push_back(smp_row(48'sd1));
		directed_steps.push_back(smp_row(SMP_MAX));
		directed_steps.push_back(smp_row('0));
		// most positive settings, wraps freely
		directed_steps.push_back(cfg_row(REG_FEEDBACK, 32'h7FFF_FFFF));
		directed_steps.push_back(cfg_row(REG_GAIN, 32'h7FFF_FFFF));
		directed_steps.push_back(cfg_row(REG_INTERVAL, 32'h0000_FFFF));
		directed_steps.push_back(smp_row(SMP_MIN));
		directed_steps.push_back(smp_row(SMP_MAX));
		directed_steps.push_back(smp_row(48'h5555_5555_5555));
		directed_steps.push_back(smp_row(48'hAAAA_AAAA_AAAA));
		// decaying smoother, then shorten the interval under the position
		directed_steps.push_back(cfg_row(REG_FEEDBACK, -32'sd64880));
		directed_steps.push_back(cfg_row(REG_GAIN, 32'd1));
		directed_steps.push_back(cfg_row(REG_INTERVAL, 32'd4));
		directed_steps.push_back(smp_row(48'sd1000));
		directed_steps.push_back(smp_row(48'sd2000));
		directed_steps.push_back(cfg_row(REG_INTERVAL, 32'd2));
		directed_steps.push_back(smp_row(48'sd3000));
		directed_steps.push_back(smp_row(48'sd4000));
		directed_steps.push_back(smp_row('0));
		directed_steps.push_back(smp_row(48'sd50));

		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (idx = 0; idx < directed_steps.size(); idx++) begin
			if (directed_steps[idx].is_cfg)
				write_reg(directed_steps[idx].reg_sel, directed_steps[idx].data);
			else
				send_sample(directed_steps[idx].sample, directed_steps[idx].typed,
					directed_steps[idx].level);
		end

		for (phase = 0; phase < RAND_PHASES; phase++) begin
			write_reg(REG_FEEDBACK, pick_coef(1'b0));
			write_reg(REG_GAIN, pick_coef(1'b1));
			write_reg(REG_INTERVAL, pick_len());
			quiet = (phase % 3 == 2);
			for (idx = 0; idx < PHASE_ITEMS; idx++)
				send_sample(pick_sample(), 1'b0, no_level);
		end

		sample_ch.valid <= 1'b0;
		wait_drain();
		repeat (2 * PIPE_LAT) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/eld_pkg.sv
src/eld_if.sv
src/exponential_level_detector_top.sv
tb/sv/tb_exponential_level_detector_top.sv
